[rtl/core/apsp_pkg.sv]
// ----------------------------------------------------------------------------
// All-pairs shortest path package
// Shared widths, item types, operation codes and controller command bundle.
// ----------------------------------------------------------------------------
package apsp_pkg;

	localparam int MAX_VERTICES   = 16;
	localparam int VIDX_W         = $clog2(MAX_VERTICES);
	localparam int ADDR_W         = 2 * VIDX_W;
	localparam int WEIGHT_WIDTH   = 16;
	localparam int DISTANCE_WIDTH = 24;
	localparam int COUNT_W        = 5;
	localparam int PRED_W         = 5;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_RUN  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// Memory address selection used by the datapath.
	localparam logic [1:0] AM_ITEM = 2'd0;
	localparam logic [1:0] AM_SNAP = 2'd1;
	localparam logic [1:0] AM_UPD  = 2'd2;
	localparam logic [1:0] AM_CHK  = 2'd3;

	typedef struct packed {
		logic [1:0]                     opcode;
		logic [VIDX_W-1:0]              row;
		logic [VIDX_W-1:0]              column;
		logic signed [WEIGHT_WIDTH-1:0] edge_weight;
		logic                           edge_infinite;
	} in_item_t;

	typedef struct packed {
		logic signed [DISTANCE_WIDTH-1:0] distance;
		logic                             distance_infinite;
		logic [PRED_W-1:0]                predecessor;
		logic                             negative_cycle;
	} out_item_t;

	typedef struct packed {
		logic                             inf;
		logic signed [DISTANCE_WIDTH-1:0] val;
		logic [PRED_W-1:0]                pred;
	} mem_entry_t;

	typedef struct packed {
		logic              accept;
		logic [1:0]        addr_mode;
		logic [VIDX_W-1:0] i;
		logic [VIDX_W-1:0] j;
		logic [VIDX_W-1:0] k;
		logic              snap_v;
		logic              upd_v;
		logic              chk_v;
		logic              clr_flag;
		logic              resp_run;
	} ctl_cmd_t;

endpackage

[rtl/core/all_pairs_shortest_path_core.sv]
// Load, read and undefined items: one item per cycle, result two cycles after the transfer.
// A run over n vertices holds busy high; its result strobes after the pivot rounds and the
// diagonal check, the relaxation sweep reading one matrix entry per cycle.
// Results leave on a one-cycle strobe; the receiver cannot stall.
// Reset clears control state and the negative cycle flag and sets the vertex count to 16;
// matrix contents are undefined until loaded.
// ----------------------------------------------------------------------------
// All-pairs shortest path core
// Floyd-Warshall shortest paths with predecessors over a 16 x 16 matrix,
// split into a sequencing controller and a matrix datapath.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_core import apsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  in_item_t           in_item,
	output out_item_t          result,
	output logic               result_valid,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COUNT_W-1:0] cfg_data
);

	ctl_cmd_t cmd;

	apsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.opcode    (in_item.opcode),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd)
	);

	apsp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_item      (in_item),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

[rtl/core/apsp_ctrl.sv]
// ----------------------------------------------------------------------------
// All-pairs shortest path controller
// Holds the vertex count register and sequences the pivot rounds of a run:
// snapshot, relaxation sweep, settle cycle, then the diagonal check.
// ----------------------------------------------------------------------------
module apsp_ctrl import apsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         opcode,
	output logic               busy,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COUNT_W-1:0] cfg_data,
	output ctl_cmd_t           cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SNAP = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_GAP  = 3'd3;
	localparam logic [2:0] S_CHK  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_RESP = 3'd6;

	logic [2:0]         state_q;
	logic [COUNT_W-1:0] vertex_count_q;
	logic [VIDX_W-1:0]  i_q, j_q, k_q;
	logic [COUNT_W-1:0] n;
	logic [VIDX_W-1:0]  n_last;
	logic               accept;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;

	assign n      = (vertex_count_q > COUNT_W'(MAX_VERTICES)) ?
		COUNT_W'(MAX_VERTICES) : vertex_count_q;
	assign n_last = VIDX_W'(n - COUNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= COUNT_W'(MAX_VERTICES);
		end else if (cfg_valid && cfg_ready) begin
			vertex_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && opcode == OP_RUN) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= (n == '0) ? S_RESP : S_SNAP;
					end
				end
				S_SNAP: begin
					if (i_q == n_last) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= S_UPD;
					end else begin
						i_q <= i_q + VIDX_W'(1);
					end
				end
				S_UPD: begin
					if (j_q == n_last) begin
						j_q <= '0;
						if (i_q == n_last) begin
							i_q     <= '0;
							state_q <= S_GAP;
						end else begin
							i_q <= i_q + VIDX_W'(1);
						end
					end else begin
						j_q <= j_q + VIDX_W'(1);
					end
				end
				S_GAP: begin
					// The last relaxation write lands here, before the next reads.
					if (k_q == n_last) begin
						k_q     <= '0;
						state_q <= S_CHK;
					end else begin
						k_q     <= k_q + VIDX_W'(1);
						state_q <= S_SNAP;
					end
				end
				S_CHK: begin
					if (i_q == n_last) begin
						i_q     <= '0;
						state_q <= S_FIN;
					end else begin
						i_q <= i_q + VIDX_W'(1);
					end
				end
				S_FIN: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.addr_mode = AM_ITEM;
		cmd.i         = i_q;
		cmd.j         = j_q;
		cmd.k         = k_q;
		case (state_q)
			S_IDLE: begin
				cmd.clr_flag = accept && opcode == OP_RUN;
			end
			S_SNAP: begin
				cmd.addr_mode = AM_SNAP;
				cmd.snap_v    = 1'b1;
			end
			S_UPD: begin
				cmd.addr_mode = AM_UPD;
				cmd.upd_v     = 1'b1;
			end
			S_CHK: begin
				cmd.addr_mode = AM_CHK;
				cmd.chk_v     = 1'b1;
			end
			S_RESP: begin
				cmd.resp_run = 1'b1;
			end
			default: begin
				cmd.addr_mode = AM_ITEM;
			end
		endcase
	end

endmodule

[rtl/core/apsp_datapath.sv]
// ----------------------------------------------------------------------------
// All-pairs shortest path datapath
// Distance and predecessor memory, pivot row and column snapshots, the
// saturating add and compare, the negative cycle flag and the result register.
// ----------------------------------------------------------------------------
module apsp_datapath import apsp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ctl_cmd_t  cmd,
	input  in_item_t  in_item,
	output out_item_t result,
	output logic      result_valid
);

	localparam logic signed [DISTANCE_WIDTH-1:0] DIST_MAX =
		{1'b0, {(DISTANCE_WIDTH-1){1'b1}}};
	localparam logic signed [DISTANCE_WIDTH-1:0] DIST_MIN =
		{1'b1, {(DISTANCE_WIDTH-1){1'b0}}};

	mem_entry_t mem [2**ADDR_W];
	mem_entry_t rd_a_q, rd_b_q;
	logic [ADDR_W-1:0] ra_a, ra_b, wa;
	mem_entry_t        wd;
	logic              we;

	logic signed [DISTANCE_WIDTH-1:0] prow_d [MAX_VERTICES];
	logic                             prow_inf [MAX_VERTICES];
	logic [PRED_W-1:0]                prow_p [MAX_VERTICES];
	logic signed [DISTANCE_WIDTH-1:0] pcol_d [MAX_VERTICES];
	logic                             pcol_inf [MAX_VERTICES];

	logic              snap_v_s1, upd_v_s1, chk_v_s1, item_v_s1, is_read_s1;
	logic [VIDX_W-1:0] i_s1, j_s1;
	logic              neg_flag_q;
	logic              result_valid_q;
	out_item_t         result_q;

	logic signed [DISTANCE_WIDTH:0]   sum;
	logic signed [DISTANCE_WIDTH-1:0] sum_sat;
	logic                             sum_inf;
	logic                             shorter;

	always_comb begin
		case (cmd.addr_mode)
			AM_SNAP: begin
				ra_a = {cmd.k, cmd.i};
				ra_b = {cmd.i, cmd.k};
			end
			AM_UPD: begin
				ra_a = {cmd.i, cmd.j};
				ra_b = {cmd.i, cmd.j};
			end
			AM_CHK: begin
				ra_a = {cmd.i, cmd.i};
				ra_b = {cmd.i, cmd.i};
			end
			default: begin
				ra_a = {in_item.row, in_item.column};
				ra_b = {in_item.row, in_item.column};
			end
		endcase
	end

	// Path through the pivot: column entry of row i plus row entry of column j.
	always_comb begin
		sum     = {pcol_d[i_s1][DISTANCE_WIDTH-1], pcol_d[i_s1]} +
		          {prow_d[j_s1][DISTANCE_WIDTH-1], prow_d[j_s1]};
		sum_inf = pcol_inf[i_s1] || prow_inf[j_s1];
		if (sum[DISTANCE_WIDTH] != sum[DISTANCE_WIDTH-1]) begin
			sum_sat = sum[DISTANCE_WIDTH] ? DIST_MIN : DIST_MAX;
		end else begin
			sum_sat = sum[DISTANCE_WIDTH-1:0];
		end
		shorter = !sum_inf && (rd_a_q.inf || sum_sat < rd_a_q.val);
	end

	always_comb begin
		we = 1'b0;
		wa = {in_item.row, in_item.column};
		wd = '0;
		if (cmd.accept && in_item.opcode == OP_LOAD) begin
			we      = 1'b1;
			wd.inf  = in_item.edge_infinite;
			wd.val  = in_item.edge_infinite ? '0 : DISTANCE_WIDTH'(in_item.edge_weight);
			wd.pred = (in_item.row == in_item.column || in_item.edge_infinite) ?
				'0 : PRED_W'({1'b0, in_item.row} + (VIDX_W + 1)'(1));
		end else if (upd_v_s1 && shorter) begin
			we      = 1'b1;
			wa      = {i_s1, j_s1};
			wd.inf  = 1'b0;
			wd.val  = sum_sat;
			wd.pred = prow_p[j_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a_q <= mem[ra_a];
		rd_b_q <= mem[ra_b];
	end

	always_ff @(posedge clk) begin
		if (snap_v_s1) begin
			prow_d[i_s1]   <= rd_a_q.val;
			prow_inf[i_s1] <= rd_a_q.inf;
			prow_p[i_s1]   <= rd_a_q.pred;
			pcol_d[i_s1]   <= rd_b_q.val;
			pcol_inf[i_s1] <= rd_b_q.inf;
		end
		i_s1       <= cmd.i;
		j_s1       <= cmd.j;
		is_read_s1 <= in_item.opcode == OP_READ;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_v_s1 <= 1'b0;
			upd_v_s1  <= 1'b0;
			chk_v_s1  <= 1'b0;
			item_v_s1 <= 1'b0;
		end else begin
			snap_v_s1 <= cmd.snap_v;
			upd_v_s1  <= cmd.upd_v;
			chk_v_s1  <= cmd.chk_v;
			item_v_s1 <= cmd.accept && in_item.opcode != OP_RUN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_flag_q <= 1'b0;
		end else if (cmd.clr_flag) begin
			neg_flag_q <= 1'b0;
		end else if (chk_v_s1 && !rd_a_q.inf && rd_a_q.val < 0) begin
			neg_flag_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= item_v_s1 || cmd.resp_run;
		end
	end

	always_ff @(posedge clk) begin
		if (item_v_s1 && is_read_s1) begin
			result_q.distance          <= rd_a_q.inf ? '0 : rd_a_q.val;
			result_q.distance_infinite <= rd_a_q.inf;
			result_q.predecessor       <= rd_a_q.pred;
		end else begin
			result_q.distance          <= '0;
			result_q.distance_infinite <= 1'b0;
			result_q.predecessor       <= '0;
		end
		result_q.negative_cycle <= neg_flag_q;
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule
